>>> hw/rtl/assert_macros.svh
// assertion macros for the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that holds on every clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked from the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/mesi_pkg.sv
// shared types and constants of the mesi l1 cache controller
package mesi_pkg;

    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_STORE = 2'd1;
    localparam logic [1:0] MODE_SNOOP = 2'd2;

    localparam logic [1:0] ST_I = 2'd0;
    localparam logic [1:0] ST_S = 2'd1;
    localparam logic [1:0] ST_E = 2'd2;
    localparam logic [1:0] ST_M = 2'd3;

    localparam logic [1:0] REQ_NONE = 2'd0;
    localparam logic [1:0] REQ_READ = 2'd1;
    localparam logic [1:0] REQ_RFO  = 2'd2;
    localparam logic [1:0] REQ_UPG  = 2'd3;

    localparam int EVICT_LINE_BITS = 42;
    localparam int WAY_OUT_BITS    = 3;

    typedef enum logic [1:0] {
        t_CLEAR,
        t_IDLE,
        t_LOOKUP,
        t_DONE
    } t_state;

endpackage

>>> hw/rtl/mesi_set_assoc_l1_cache_unit.sv
// top level: tag, mesi state and true-lru controller of a set-associative l1 cache
// an accepted transaction reads its set into a register, then lookup registers the result and writes the set back
// a new transaction is taken only in idle, after the last one has passed lookup and done (set read-modify-write)
// no transaction is accepted while a finished result still waits on a stalled output
// reset: a clearing pass writes every set to invalid and index-order lru, one set after another
// no transaction is accepted during the clearing pass
`include "assert_macros.svh"

module mesi_set_assoc_l1_cache_unit #(
    parameter int SETS       = 64,
    parameter int WAYS       = 8,
    parameter int LINE_BYTES = 64,
    parameter int ADDR_BITS  = 48
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    output logic                                    o_stall,
    input  logic [1:0]                              i_mode,
    input  logic [47:0]                             i_address,
    input  logic [1:0]                              i_snoop_state,
    output logic                                    o_valid,
    input  logic                                    i_stall,
    output logic                                    o_hit,
    output logic [mesi_pkg::WAY_OUT_BITS-1:0]       o_way_used,
    output logic [1:0]                              o_old_state,
    output logic [1:0]                              o_next_request,
    output logic                                    o_evict_valid,
    output logic [mesi_pkg::EVICT_LINE_BITS-1:0]    o_evict_line,
    output logic                                    o_evict_dirty
);

    localparam int OFF_BITS  = $clog2(LINE_BYTES);
    localparam int SET_BITS  = $clog2(SETS);
    localparam int WAY_BITS  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int TAG_BITS  = ADDR_BITS - OFF_BITS - SET_BITS;
    localparam int USE_BITS  = (ADDR_BITS < 48) ? ADDR_BITS : 48;
    localparam int LRU_BITS  = WAYS * WAY_BITS;
    localparam int ROW_BITS  = WAYS * (TAG_BITS + 2) + LRU_BITS;
    localparam int EL        = mesi_pkg::EVICT_LINE_BITS;
    localparam int LINE_W    = TAG_BITS + SET_BITS;

    typedef logic [TAG_BITS-1:0] t_tag;
    typedef logic [WAY_BITS-1:0] t_way;

    logic [ROW_BITS-1:0] mem [SETS];
    logic [ROW_BITS-1:0] r_rdata;

    mesi_pkg::t_state r_state, n_state;
    logic [SET_BITS-1:0] r_clr, n_clr;
    logic [1:0]  r_mode;
    t_tag        r_tag;
    logic [SET_BITS-1:0] r_set;
    logic [1:0]  r_snoop;

    logic        r_ovalid;
    logic        r_hit;
    t_way        r_way;
    logic [1:0]  r_old, r_req;
    logic        r_ev, r_evd;
    logic [EL-1:0] r_evl;

    logic [USE_BITS-1:0] addr_use;
    logic        accept;
    logic        wr_en;
    logic [SET_BITS-1:0] wr_addr;
    logic [ROW_BITS-1:0] wr_data;

    t_tag        tags [WAYS];
    logic [1:0]  sts  [WAYS];
    t_way        lru  [WAYS];
    t_tag        n_tags [WAYS];
    logic [1:0]  n_sts  [WAYS];
    t_way        n_lru  [WAYS];

    logic        found, freeway, touch_en;
    t_way        fway, iway, way;
    logic        c_hit, c_ev, c_evd;
    logic [1:0]  c_old, c_req;
    logic [LINE_W-1:0] c_line;

    assign addr_use = i_address[USE_BITS-1:0];
    assign accept   = i_valid && !o_stall;
    assign o_stall  = (r_state != mesi_pkg::t_IDLE) || (r_ovalid && i_stall);

    always_comb begin
        n_state = r_state;
        n_clr   = r_clr;
        case (r_state)
            mesi_pkg::t_CLEAR: begin
                n_clr = r_clr + 1'b1;
                if (r_clr == SET_BITS'(SETS - 1)) n_state = mesi_pkg::t_IDLE;
            end
            mesi_pkg::t_IDLE:   if (accept) n_state = mesi_pkg::t_LOOKUP;
            mesi_pkg::t_LOOKUP: n_state = mesi_pkg::t_DONE;
            mesi_pkg::t_DONE:   if (!(r_ovalid && i_stall)) n_state = mesi_pkg::t_IDLE;
            default:            n_state = mesi_pkg::t_IDLE;
        endcase
    end

    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            tags[w] = r_rdata[w*(TAG_BITS+2) +: TAG_BITS];
            sts[w]  = r_rdata[w*(TAG_BITS+2) + TAG_BITS +: 2];
            lru[w]  = r_rdata[WAYS*(TAG_BITS+2) + w*WAY_BITS +: WAY_BITS];
        end
    end

    always_comb begin
        found = 1'b0;
        fway  = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (sts[w] != mesi_pkg::ST_I && tags[w] == r_tag) begin
                found = 1'b1;
                fway  = t_way'(w);
            end
        end
        freeway = 1'b0;
        iway    = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (sts[w] == mesi_pkg::ST_I) begin
                freeway = 1'b1;
                iway    = t_way'(w);
            end
        end
    end

    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            n_tags[w] = tags[w];
            n_sts[w]  = sts[w];
        end
        c_hit    = 1'b0;
        c_old    = mesi_pkg::ST_I;
        c_req    = mesi_pkg::REQ_NONE;
        c_ev     = 1'b0;
        c_evd    = 1'b0;
        c_line   = '0;
        way      = '0;
        touch_en = 1'b0;
        case (r_mode)
            mesi_pkg::MODE_SNOOP: begin
                if (found) begin
                    c_hit       = 1'b1;
                    way         = fway;
                    c_old       = sts[fway];
                    n_sts[fway] = r_snoop;
                end
            end
            mesi_pkg::MODE_LOAD, mesi_pkg::MODE_STORE: begin
                touch_en = 1'b1;
                if (found) begin
                    c_hit = 1'b1;
                    way   = fway;
                    c_old = sts[fway];
                    if (r_mode == mesi_pkg::MODE_STORE) begin
                        if (sts[fway] == mesi_pkg::ST_S) c_req = mesi_pkg::REQ_UPG;
                        n_sts[fway] = mesi_pkg::ST_M;
                    end
                end else begin
                    if (freeway) begin
                        way = iway;
                    end else begin
                        way    = lru[0];
                        c_ev   = 1'b1;
                        c_evd  = (sts[lru[0]] == mesi_pkg::ST_M);
                        c_line = {tags[lru[0]], r_set};
                    end
                    n_tags[way] = r_tag;
                    n_sts[way]  = (r_mode == mesi_pkg::MODE_STORE) ? mesi_pkg::ST_M
                                                                  : mesi_pkg::ST_E;
                    c_req       = (r_mode == mesi_pkg::MODE_STORE) ? mesi_pkg::REQ_RFO
                                                                  : mesi_pkg::REQ_READ;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        logic seen;
        seen = 1'b0;
        for (int w = 0; w < WAYS; w++) begin
            if (lru[w] == way) seen = 1'b1;
            if (!touch_en) n_lru[w] = lru[w];
            else if (w == WAYS - 1) n_lru[w] = way;
            else if (seen || lru[w] == way) n_lru[w] = lru[w+1];
            else n_lru[w] = lru[w];
        end
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_set;
        wr_data = '0;
        if (r_state == mesi_pkg::t_CLEAR) begin
            wr_en   = 1'b1;
            wr_addr = r_clr;
            for (int w = 0; w < WAYS; w++)
                wr_data[WAYS*(TAG_BITS+2) + w*WAY_BITS +: WAY_BITS] = t_way'(w);
        end else if (r_state == mesi_pkg::t_LOOKUP) begin
            wr_en = 1'b1;
            for (int w = 0; w < WAYS; w++) begin
                wr_data[w*(TAG_BITS+2) +: TAG_BITS] = n_tags[w];
                wr_data[w*(TAG_BITS+2) + TAG_BITS +: 2] = n_sts[w];
                wr_data[WAYS*(TAG_BITS+2) + w*WAY_BITS +: WAY_BITS] = n_lru[w];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        r_rdata <= mem[addr_use[OFF_BITS +: SET_BITS]];
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode  <= i_mode;
            r_set   <= addr_use[OFF_BITS +: SET_BITS];
            r_tag   <= t_tag'(addr_use >> (OFF_BITS + SET_BITS));
            r_snoop <= i_snoop_state;
        end
        if (r_state == mesi_pkg::t_LOOKUP) begin
            r_hit <= c_hit;
            r_way <= way;
            r_old <= c_old;
            r_req <= c_req;
            r_ev  <= c_ev;
            r_evd <= c_evd;
            r_evl <= EL'(c_line);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= mesi_pkg::t_CLEAR;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            if (r_state == mesi_pkg::t_LOOKUP) r_ovalid <= 1'b1;
            else if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
        end
    end

    assign o_valid        = r_ovalid;
    assign o_hit          = r_hit;
    assign o_way_used     = mesi_pkg::WAY_OUT_BITS'(r_way);
    assign o_old_state    = r_old;
    assign o_next_request = r_req;
    assign o_evict_valid  = r_ev;
    assign o_evict_line   = r_evl;
    assign o_evict_dirty  = r_evd;

    `ASSERT_NEXT(a_accept_lookup, i_clk, i_rst_n, accept, r_state == mesi_pkg::t_LOOKUP, "accept did not start lookup")
    `ASSERT_NEXT(a_lookup_result, i_clk, i_rst_n, r_state == mesi_pkg::t_LOOKUP, r_ovalid, "lookup gave no result")
    `ASSERT_CLK(a_no_accept_clear, i_clk, i_rst_n, !(accept && r_state == mesi_pkg::t_CLEAR), "accept during clear")
    `ASSERT_CLK(a_evict_miss, i_clk, i_rst_n, !(r_ovalid && r_ev && r_hit), "eviction on a hit")

endmodule
